// ===== design/wres_pkg.sv =====
// Package for the weighted random entry select block: sizes, codes, microcode ROM.
// No dependencies; every other design file imports it.
package wres_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int WEIGHT_BITS = 8;

    localparam int IDENT_W  = 24;
    localparam int CLASS_W  = 3;
    localparam int INDEX_W  = 4;
    localparam int WIN_W    = 8;
    localparam int MASK_W   = 16;
    localparam int RND_W    = 31;

    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SUM_W      = WEIGHT_BITS + $clog2(NUM_SLOTS);
    localparam int DIV_STEPS  = (RND_W + 1) / 2;
    localparam int DIVIDEND_W = 2 * DIV_STEPS;
    localparam int DIV_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int PC_W       = 3;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SELECT = 1'b1;

    localparam logic [CLASS_W-1:0] CLS_DAY        = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_NIGHT      = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_DAY_ONLY   = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_NIGHT_ONLY = 3'd4;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_SUM_INIT,
        OP_ACC,
        OP_DIV_INIT,
        OP_DIV,
        OP_WALK_INIT,
        OP_WALK,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        CND_NEVER,
        CND_NO_START,
        CND_SUM_MORE,
        CND_TOTAL_ZERO,
        CND_DIV_MORE,
        CND_WALK_MORE,
        CND_OUT_BUSY
    } cond_t;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_IDLE      = 3'd0;
    localparam pc_t PC_SUM_INIT  = 3'd1;
    localparam pc_t PC_SUM       = 3'd2;
    localparam pc_t PC_CHECK     = 3'd3;
    localparam pc_t PC_DIV       = 3'd4;
    localparam pc_t PC_WALK_INIT = 3'd5;
    localparam pc_t PC_WALK      = 3'd6;
    localparam pc_t PC_EMIT      = 3'd7;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   jump_pc;
        pc_t   next_pc;
    } uword_t;

    typedef struct packed {
        logic start;
        logic sum_more;
        logic total_zero;
        logic div_more;
        logic walk_more;
        logic out_busy;
    } status_t;

    function automatic uword_t ucode_rom(pc_t pc);
        uword_t w;
        unique case (pc)
            PC_IDLE:      w = '{OP_IDLE,      CND_NO_START,   PC_IDLE,  PC_SUM_INIT};
            PC_SUM_INIT:  w = '{OP_SUM_INIT,  CND_NEVER,      PC_IDLE,  PC_SUM};
            PC_SUM:       w = '{OP_ACC,       CND_SUM_MORE,   PC_SUM,   PC_CHECK};
            PC_CHECK:     w = '{OP_DIV_INIT,  CND_TOTAL_ZERO, PC_EMIT,  PC_DIV};
            PC_DIV:       w = '{OP_DIV,       CND_DIV_MORE,   PC_DIV,   PC_WALK_INIT};
            PC_WALK_INIT: w = '{OP_WALK_INIT, CND_NEVER,      PC_IDLE,  PC_WALK};
            PC_WALK:      w = '{OP_WALK,      CND_WALK_MORE,  PC_WALK,  PC_EMIT};
            PC_EMIT:      w = '{OP_EMIT,      CND_OUT_BUSY,   PC_EMIT,  PC_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic time_allowed(logic [CLASS_W-1:0] cls, logic day);
        logic ok;
        if (day)
        begin
            ok = !(cls == CLS_NIGHT || cls == CLS_NIGHT_ONLY);
        end
        else
        begin
            ok = !(cls == CLS_DAY || cls == CLS_DAY_ONLY);
        end
        return ok;
    endfunction

endpackage

// ===== design/wres_in_if.sv =====
// Request channel: valid/ready handshake plus write and select fields.
// Depends on wres_pkg.
interface wres_in_if
    import wres_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [INDEX_W-1:0]   entry_index;
    logic                 entry_valid;
    logic [IDENT_W-1:0]   entry_ident;
    logic [WIN_W-1:0]     entry_weight;
    logic [CLASS_W-1:0]   entry_time_class;
    logic                 is_daytime;
    logic [MASK_W-1:0]    at_limit_mask;
    logic [RND_W-1:0]     random_value;

    modport source (
        output valid, kind, entry_index, entry_valid, entry_ident, entry_weight,
               entry_time_class, is_daytime, at_limit_mask, random_value,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, entry_valid, entry_ident, entry_weight,
               entry_time_class, is_daytime, at_limit_mask, random_value,
        output ready
    );
endinterface

// ===== design/wres_out_if.sv =====
// Result channel: valid/ready handshake plus the selection result.
// Depends on wres_pkg.
interface wres_out_if
    import wres_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [IDENT_W-1:0]   chosen_ident;
    logic [CLASS_W-1:0]   chosen_time_class;

    modport source (
        output valid, found, chosen_ident, chosen_time_class,
        input  ready
    );
    modport sink (
        input  valid, found, chosen_ident, chosen_time_class,
        output ready
    );
endinterface

// ===== design/weighted_random_entry_select.sv =====
// Weighted random entry select, top level: microcode sequencer plus datapath.
// Write requests update the slot table on accept; a select request runs the sum pass,
// a radix-4 remainder and the walk (up to NUM_SLOTS slots); when nothing is eligible
// it goes straight to the emit step, which waits on an unread result; one select in flight.
// Reset: sequencer idle, all slots invalid, no result pending.
// Depends on wres_pkg, wres_in_if, wres_out_if, wres_seq, wres_datapath.
module weighted_random_entry_select
    import wres_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    wres_in_if.sink    req,
    wres_out_if.source rsp
);

    op_t     op;
    pc_t     pc;
    status_t status;

    wres_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op),
        .pc     (pc)
    );

    wres_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .idle   (pc == PC_IDLE),
        .status (status),
        .req    (req),
        .rsp    (rsp)
    );

endmodule

// ===== design/wres_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on wres_pkg (ROM contents, op and condition codes).
module wres_seq
    import wres_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output op_t     op,
    output pc_t     pc
);

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t uw;
    logic   take;

    assign uw = ucode_rom(pc_reg);
    assign op = uw.op;
    assign pc = pc_reg;

    always_comb
    begin
        unique case (uw.cond)
            CND_NEVER:      take = 1'b0;
            CND_NO_START:   take = !status.start;
            CND_SUM_MORE:   take = status.sum_more;
            CND_TOTAL_ZERO: take = status.total_zero;
            CND_DIV_MORE:   take = status.div_more;
            CND_WALK_MORE:  take = status.walk_more;
            CND_OUT_BUSY:   take = status.out_busy;
            default:        take = 1'b0;
        endcase
        pc_next = take ? uw.jump_pc : uw.next_pc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== design/wres_datapath.sv =====
// Datapath: slot table, weight accumulator, radix-4 remainder unit, walk and result register.
// Depends on wres_pkg, wres_in_if and wres_out_if; driven by wres_seq.
module wres_datapath
    import wres_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  op_t       op,
    input  logic      idle,
    output status_t   status,
    wres_in_if.sink   req,
    wres_out_if.source rsp
);

    localparam logic [SLOT_W-1:0]    SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(DIV_STEPS - 1);

    logic                   slot_valid_reg [NUM_SLOTS];
    logic [IDENT_W-1:0]     slot_ident_reg [NUM_SLOTS];
    logic [WEIGHT_BITS-1:0] slot_weight_reg [NUM_SLOTS];
    logic [CLASS_W-1:0]     slot_class_reg [NUM_SLOTS];

    logic                   day_reg;
    logic [MASK_W-1:0]      mask_reg;
    logic [RND_W-1:0]       rnd_reg;
    logic [SLOT_W-1:0]      ptr_reg;
    logic [SUM_W-1:0]       total_reg;
    logic [SUM_W-1:0]       rem_reg;
    logic [SUM_W-1:0]       roll_reg;
    logic [DIVIDEND_W-1:0]  dividend_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic                   found_reg;
    logic [IDENT_W-1:0]     chosen_ident_reg;
    logic [CLASS_W-1:0]     chosen_class_reg;
    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [IDENT_W-1:0]     out_ident_reg;
    logic [CLASS_W-1:0]     out_class_reg;

    logic                   accept;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_slot;
    logic [MASK_W-1:0]      mask_shift;
    logic                   elig;
    logic [SUM_W-1:0]       cur_weight;
    logic                   hit;
    logic                   out_busy;
    logic [SUM_W:0]         t1;
    logic [SUM_W:0]         t2;
    logic [SUM_W-1:0]       r1;
    logic [SUM_W-1:0]       r2;

    assign req.ready = idle;
    assign accept    = req.valid && req.ready;
    assign wr_en     = accept && (req.kind == KIND_WRITE)
                       && (32'(req.entry_index) < NUM_SLOTS);
    assign wr_slot   = SLOT_W'(req.entry_index);

    assign mask_shift = mask_reg >> ptr_reg;
    assign cur_weight = SUM_W'(slot_weight_reg[ptr_reg]);
    assign elig = slot_valid_reg[ptr_reg]
                  && (slot_weight_reg[ptr_reg] != '0)
                  && (slot_ident_reg[ptr_reg] != '0)
                  && !mask_shift[0]
                  && time_allowed(slot_class_reg[ptr_reg], day_reg);
    assign hit = elig && (roll_reg < cur_weight);

    assign out_busy = out_valid_reg && !rsp.ready;

    // two restoring division steps per cycle
    always_comb
    begin
        t1 = {rem_reg, dividend_reg[DIVIDEND_W-1]};
        r1 = (t1 >= {1'b0, total_reg}) ? SUM_W'(t1 - {1'b0, total_reg}) : SUM_W'(t1);
        t2 = {r1, dividend_reg[DIVIDEND_W-2]};
        r2 = (t2 >= {1'b0, total_reg}) ? SUM_W'(t2 - {1'b0, total_reg}) : SUM_W'(t2);
    end

    always_comb
    begin
        status.start      = accept && (req.kind == KIND_SELECT);
        status.sum_more   = ptr_reg != SLOT_LAST;
        status.total_zero = total_reg == '0;
        status.div_more   = cnt_reg != DIV_LAST;
        status.walk_more  = (ptr_reg != SLOT_LAST) && !hit;
        status.out_busy   = out_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
        end
        else if (wr_en)
        begin
            slot_valid_reg[wr_slot] <= req.entry_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_ident_reg[wr_slot]  <= req.entry_ident;
            slot_weight_reg[wr_slot] <= WEIGHT_BITS'(req.entry_weight);
            slot_class_reg[wr_slot]  <= req.entry_time_class;
        end
        if (status.start)
        begin
            day_reg  <= req.is_daytime;
            mask_reg <= req.at_limit_mask;
            rnd_reg  <= req.random_value;
        end
        unique case (op)
            OP_IDLE:
            begin
            end
            OP_SUM_INIT:
            begin
                ptr_reg          <= '0;
                total_reg        <= '0;
                found_reg        <= 1'b0;
                chosen_ident_reg <= '0;
                chosen_class_reg <= '0;
            end
            OP_ACC:
            begin
                if (elig)
                begin
                    total_reg <= total_reg + cur_weight;
                end
                ptr_reg <= ptr_reg + 1'b1;
            end
            OP_DIV_INIT:
            begin
                rem_reg      <= '0;
                cnt_reg      <= '0;
                dividend_reg <= DIVIDEND_W'(rnd_reg);
            end
            OP_DIV:
            begin
                rem_reg      <= r2;
                dividend_reg <= dividend_reg << 2;
                cnt_reg      <= cnt_reg + 1'b1;
            end
            OP_WALK_INIT:
            begin
                ptr_reg  <= '0;
                roll_reg <= rem_reg;
            end
            OP_WALK:
            begin
                if (hit)
                begin
                    found_reg        <= 1'b1;
                    chosen_ident_reg <= slot_ident_reg[ptr_reg];
                    chosen_class_reg <= slot_class_reg[ptr_reg];
                end
                else if (elig)
                begin
                    roll_reg <= roll_reg - cur_weight;
                end
                ptr_reg <= ptr_reg + 1'b1;
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_found_reg <= found_reg;
                    out_ident_reg <= chosen_ident_reg;
                    out_class_reg <= chosen_class_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (op == OP_EMIT && !out_busy)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.found             = out_found_reg;
    assign rsp.chosen_ident      = out_ident_reg;
    assign rsp.chosen_time_class = out_class_reg;

`ifndef SYNTHESIS
    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_EMIT && !out_busy) |=> out_valid_reg)
        else $error("result not presented after emit step");

    a_found_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.found) |-> (rsp.chosen_ident != '0))
        else $error("found result with zero identifier");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.chosen_ident == '0 && rsp.chosen_time_class == '0))
        else $error("not-found result carries nonzero fields");

    a_roll_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_WALK) |-> (roll_reg < total_reg))
        else $error("roll out of range during walk");
`endif

endmodule
